// File: rtl/tbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared types, constants and helper functions of the token bucket shaper.
// ----------------------------------------------------------------------------
package tbps_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH  = 2048;
    localparam int MAX_RELEASES = 63;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W        = $clog2(MAX_RELEASES + 1);

    // field widths
    localparam int ELAPSED_W = 16;
    localparam int ID_W      = 16;
    localparam int LEN_W     = 16;
    localparam int KIND_W    = 2;
    localparam int QC_W      = 12;
    localparam int RATE_W    = 17;
    localparam int LIMIT_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;
    localparam int DESC_W    = ID_W + LEN_W;

    // token arithmetic, thousandths of a byte
    localparam int TOK_W    = 38;
    localparam int FILL_W   = ELAPSED_W + RATE_W;
    localparam int FILL_SH  = 10;
    localparam int SUM_W    = FILL_W + FILL_SH + 1;
    localparam int COST_W   = LEN_W + 10;
    localparam int CAP_SH   = 10;
    localparam int CAPP_W   = TOK_W - CAP_SH;

    localparam logic [RATE_W-1:0]  RATE_MAX = RATE_W'(99999);
    localparam logic [TOK_W-1:0]   MIN_CAP  = TOK_W'(65535000);
    localparam logic [CAPP_W-1:0]  CAP_KB   = CAPP_W'(2000);
    localparam logic [COST_W-1:0]  MILLI    = COST_W'(1000);

    // register reset values
    localparam logic [RATE_W-1:0]  RST_RATE   = RATE_W'(10);
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = LIMIT_W'(2000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT  = 2'd3;

    // input command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PASS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

    // classified operations from the front part
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PASS  = 2'd1;
    localparam logic [1:0] OP_SHAPE = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [ELAPSED_W-1:0] elapsed;
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
    } t_item;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic               in_en;
        logic               out_en;
        logic [LIMIT_W-1:0] qlimit;
    } t_cfg;

    // bucket capacity: max(65535000, rate * 2048000)
    function automatic logic [TOK_W-1:0] f_capacity(input logic [RATE_W-1:0] rate);
        logic [CAPP_W-1:0] p;
        logic [TOK_W-1:0]  c;
        p = CAPP_W'(rate) * CAP_KB;
        c = {p, CAP_SH'(0)};
        return (c < MIN_CAP) ? MIN_CAP : c;
    endfunction

    // circular pointer advance
    function automatic logic [PTR_W-1:0] f_ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tbps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/tbps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_front
// Accepts input words, classifies them as tick, pass-through or shaped
// packet, and holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module tbps_front
    import tbps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic [ELAPSED_W-1:0] i_elapsed_ms,
    input  wire logic [ID_W-1:0]      i_packet_id,
    input  wire logic [LEN_W-1:0]     i_packet_len,
    input  wire logic                 i_outbound,
    output logic                      o_item_valid,
    output t_item                     o_item,
    input  wire logic                 i_pop
);

    t_item      r_q [2];
    logic       r_qw, n_qw;
    logic       r_qr, n_qr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       shaped;
    t_item      cls;

    // classify the incoming word
    always_comb begin
        shaped = i_outbound ? i_cfg.out_en : i_cfg.in_en;
        if (i_cmd == CMD_TICK) begin
            cls.op = OP_TICK;
        end else if (shaped) begin
            cls.op = OP_SHAPE;
        end else begin
            cls.op = OP_PASS;
        end
        cls.elapsed = i_elapsed_ms;
        cls.id      = i_packet_id;
        cls.len     = i_packet_len;
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_qr];

    // queue pointers and fill count
    always_comb begin
        n_qw  = r_qw ^ push;
        n_qr  = r_qr ^ (i_pop && o_item_valid);
        n_cnt = r_cnt + 2'(push) - 2'(i_pop && o_item_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw  <= 1'b0;
            r_qr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_qw  <= n_qw;
            r_qr  <= n_qr;
            r_cnt <= n_cnt;
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_qw] <= cls;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tbps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_back
// Token bucket, descriptor FIFO and release sequencer. Takes one classified
// item at a time and delivers its result words through an output register.
// ----------------------------------------------------------------------------
module tbps_back
    import tbps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_cfg_wr,
    input  wire logic              i_item_valid,
    input  wire t_item             i_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [KIND_W-1:0]      o_kind,
    output logic [ID_W-1:0]        o_out_id,
    output logic [LEN_W-1:0]       o_out_len,
    output logic [QC_W-1:0]        o_queue_count,
    output logic                   o_last
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TICK_MUL = 3'd1;
    localparam logic [2:0] S_TICK_ADD = 3'd2;
    localparam logic [2:0] S_REL_RD   = 3'd3;
    localparam logic [2:0] S_REL_LD   = 3'd4;
    localparam logic [2:0] S_REL_CMP  = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // control state
    logic [2:0]           r_state, n_state;
    logic                 r_refill, n_refill;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [REL_W-1:0]     r_released, n_released;
    logic                 r_pend_valid, n_pend_valid;
    logic                 r_out_valid, n_out_valid;
    logic [TOK_W-1:0]     r_tokens, n_tokens;

    // payload
    logic [TOK_W-1:0]     r_cap;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [COST_W-1:0]    r_cost, n_cost;
    logic [ID_W-1:0]      r_rel_id, n_rel_id;
    logic [LEN_W-1:0]     r_rel_len, n_rel_len;
    logic [KIND_W-1:0]    r_pend_kind, n_pend_kind;
    logic [ID_W-1:0]      r_pend_id, n_pend_id;
    logic [LEN_W-1:0]     r_pend_len, n_pend_len;
    logic [QC_W-1:0]      r_pend_cnt, n_pend_cnt;
    logic [KIND_W-1:0]    r_out_kind, n_out_kind;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [LEN_W-1:0]     r_out_len, n_out_len;
    logic [QC_W-1:0]      r_out_cnt, n_out_cnt;
    logic                 r_out_last, n_out_last;

    logic [TOK_W-1:0]     cap_now;
    logic                 out_free;
    logic                 rate_zero;
    logic                 full;
    logic [CMP_W-1:0]     lim_eff;
    logic [SUM_W-1:0]     fill_sum;
    logic                 ram_we;
    logic [DESC_W-1:0]    ram_wdata;
    logic [DESC_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]     occ_dec;

    tbps_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign cap_now   = f_capacity(i_cfg.rate);
    assign out_free  = !r_out_valid || !i_stall;
    assign rate_zero = (i_cfg.rate == '0);
    assign lim_eff   = (CMP_W'(i_cfg.qlimit) > CMP_W'(QUEUE_DEPTH)) ?
                       CMP_W'(QUEUE_DEPTH) : CMP_W'(i_cfg.qlimit);
    assign full      = (CMP_W'(r_occ) >= lim_eff);
    assign fill_sum  = SUM_W'(r_tokens) + SUM_W'({r_fill, FILL_SH'(0)});
    assign ram_wdata = {i_item.id, i_item.len};
    assign occ_dec   = r_occ - 1'b1;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_refill     = r_refill;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_occ        = r_occ;
        n_released   = r_released;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        n_tokens     = r_tokens;
        n_fill       = r_fill;
        n_elapsed    = r_elapsed;
        n_cost       = r_cost;
        n_rel_id     = r_rel_id;
        n_rel_len    = r_rel_len;
        n_pend_kind  = r_pend_kind;
        n_pend_id    = r_pend_id;
        n_pend_len   = r_pend_len;
        n_pend_cnt   = r_pend_cnt;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_len    = r_out_len;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        ram_we       = 1'b0;

        // output word taken
        if (out_free) begin
            n_out_valid = 1'b0;
        end

        // refill to capacity after reset or a register write
        if (r_refill) begin
            n_tokens = cap_now;
            n_refill = 1'b0;
        end
        if (i_cfg_wr) begin
            n_refill = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item_valid && !r_refill && !i_cfg_wr) begin
                    o_pop      = 1'b1;
                    n_released = '0;
                    n_state    = rate_zero ? S_FLUSH : S_REL_RD;
                    case (i_item.op)
                        OP_TICK: begin
                            n_elapsed = i_item.elapsed;
                            if (!rate_zero) begin
                                n_state = S_TICK_MUL;
                            end
                        end
                        OP_PASS: begin
                            n_pend_valid = 1'b1;
                            n_pend_kind  = KIND_PASS;
                            n_pend_id    = i_item.id;
                            n_pend_len   = i_item.len;
                            n_pend_cnt   = QC_W'(r_occ);
                        end
                        OP_SHAPE: begin
                            if (full) begin
                                n_pend_valid = 1'b1;
                                n_pend_kind  = KIND_DROP;
                                n_pend_id    = i_item.id;
                                n_pend_len   = i_item.len;
                                n_pend_cnt   = QC_W'(r_occ);
                            end else begin
                                ram_we   = 1'b1;
                                n_wr_ptr = f_ptr_next(r_wr_ptr);
                                n_occ    = r_occ + 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_FLUSH;
                        end
                    endcase
                end
            end
            S_TICK_MUL: begin
                n_fill  = FILL_W'(r_elapsed) * FILL_W'(i_cfg.rate);
                n_state = S_TICK_ADD;
            end
            S_TICK_ADD: begin
                n_tokens = (fill_sum > SUM_W'(r_cap)) ? r_cap : fill_sum[TOK_W-1:0];
                n_state  = S_REL_RD;
            end
            S_REL_RD: begin
                if (r_occ == '0 || r_released == REL_W'(MAX_RELEASES)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_REL_LD;
                end
            end
            S_REL_LD: begin
                n_rel_id  = ram_rdata[DESC_W-1:LEN_W];
                n_rel_len = ram_rdata[LEN_W-1:0];
                n_cost    = COST_W'(ram_rdata[LEN_W-1:0]) * MILLI;
                n_state   = S_REL_CMP;
            end
            S_REL_CMP: begin
                if (r_tokens < TOK_W'(r_cost)) begin
                    n_state = S_FLUSH;
                end else if (!r_pend_valid || out_free) begin
                    // older pending word goes out, not the last one
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_id    = r_pend_id;
                        n_out_len   = r_pend_len;
                        n_out_cnt   = r_pend_cnt;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_kind  = KIND_RELEASE;
                    n_pend_id    = r_rel_id;
                    n_pend_len   = r_rel_len;
                    n_pend_cnt   = QC_W'(occ_dec);
                    n_tokens     = r_tokens - TOK_W'(r_cost);
                    n_rd_ptr     = f_ptr_next(r_rd_ptr);
                    n_occ        = occ_dec;
                    n_released   = r_released + 1'b1;
                    n_state      = S_REL_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_id     = r_pend_id;
                    n_out_len    = r_pend_len;
                    n_out_cnt    = r_pend_cnt;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_refill     <= 1'b1;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_occ        <= '0;
            r_released   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tokens     <= '0;
        end else begin
            r_state      <= n_state;
            r_refill     <= n_refill;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_occ        <= n_occ;
            r_released   <= n_released;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_tokens     <= n_tokens;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cap       <= cap_now;
        r_fill      <= n_fill;
        r_elapsed   <= n_elapsed;
        r_cost      <= n_cost;
        r_rel_id    <= n_rel_id;
        r_rel_len   <= n_rel_len;
        r_pend_kind <= n_pend_kind;
        r_pend_id   <= n_pend_id;
        r_pend_len  <= n_pend_len;
        r_pend_cnt  <= n_pend_cnt;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_len   <= n_out_len;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_out_id      = r_out_id;
    assign o_out_len     = r_out_len;
    assign o_queue_count = r_out_cnt;
    assign o_last        = r_out_last;

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("descriptor occupancy above queue depth");

    a_rel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_released <= REL_W'(MAX_RELEASES))
        else $error("release count above burst limit");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending result word left behind at item end");

    a_release_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL_CMP && n_state == S_REL_RD) |=> (r_occ == $past(occ_dec)))
        else $error("release did not drop occupancy by one");

endmodule
`default_nettype wire

// File: rtl/token_bucket_packet_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper
// Token bucket shaper for packet descriptors with a tail-drop FIFO.
//
// Input channel (i_valid / o_stall) carries ticks and packet arrivals; the
// result channel (o_valid / i_stall) carries release, pass-through and drop
// words, o_last marking the final word of an item. Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data and refill the bucket.
// A two-entry queue sits between the accepting front and the back part, so
// inputs are taken while results wait. The back part runs one item at a
// time: a start step, then a fill multiply and clamp for a tick at nonzero
// rate, three steps per released descriptor (pointer, store read, cost and
// token compare), a last pointer check and a step to hand over the final
// word. At zero rate nothing is released; at most 63 descriptors go out
// per item. The store read port sets the release pace.
// After reset the bucket refills to capacity; the descriptor store is not
// cleared and needs no sweep. A stalled receiver holds the output word and
// the back part waits; the front keeps taking words until its queue fills.
// ----------------------------------------------------------------------------
module token_bucket_packet_shaper
    import tbps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic [ELAPSED_W-1:0] i_elapsed_ms,
    input  wire logic [ID_W-1:0]      i_packet_id,
    input  wire logic [LEN_W-1:0]     i_packet_len,
    input  wire logic                 i_outbound,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [KIND_W-1:0]         o_kind,
    output logic [ID_W-1:0]           o_out_id,
    output logic [LEN_W-1:0]          o_out_len,
    output logic [QC_W-1:0]           o_queue_count,
    output logic                      o_last
);

    t_cfg  r_cfg, n_cfg;
    logic  cfg_hit;
    logic  item_valid;
    t_item item;
    logic  pop;

    // register writes, rate saturates at its maximum
    always_comb begin
        n_cfg   = r_cfg;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE: begin
                    n_cfg.rate = (i_cfg_data > CFG_W'(RATE_MAX)) ?
                                 RATE_MAX : i_cfg_data[RATE_W-1:0];
                    cfg_hit    = 1'b1;
                end
                CFG_IN_EN: begin
                    n_cfg.in_en = i_cfg_data[0];
                    cfg_hit     = 1'b1;
                end
                CFG_OUT_EN: begin
                    n_cfg.out_en = i_cfg_data[0];
                    cfg_hit      = 1'b1;
                end
                CFG_QLIMIT: begin
                    n_cfg.qlimit = i_cfg_data[LIMIT_W-1:0];
                    cfg_hit      = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate   <= RST_RATE;
            r_cfg.in_en  <= 1'b1;
            r_cfg.out_en <= 1'b1;
            r_cfg.qlimit <= RST_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // accept and classify
    tbps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_elapsed_ms (i_elapsed_ms),
        .i_packet_id  (i_packet_id),
        .i_packet_len (i_packet_len),
        .i_outbound   (i_outbound),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    // bucket, store and release sequencer
    tbps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cfg_wr      (cfg_hit),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_out_id      (o_out_id),
        .o_out_len     (o_out_len),
        .o_queue_count (o_queue_count),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire
